FILE: design/rrz_pkg.sv
// Shared constants, register map and helpers for the radial range to z depth block.
// No dependencies; used by the channel interfaces and the top level.
package rrz_pkg;

    // field widths
    localparam int DEPTH_W = 16;
    localparam int IDX_W   = 11;
    localparam int CFG_W   = 16;
    localparam int MAX_DIM = 2048;

    // register map (word index on the APB port)
    localparam int          ADDR_W = 4;
    localparam int          DATA_W = 32;
    localparam logic [1:0]  REG_CX = 2'd0;
    localparam logic [1:0]  REG_CY = 2'd1;
    localparam logic [1:0]  REG_FX = 2'd2;
    localparam logic [1:0]  REG_FY = 2'd3;

    localparam logic [CFG_W-1:0] CX_RST = 16'd5120;
    localparam logic [CFG_W-1:0] CY_RST = 16'd3840;
    localparam logic [CFG_W-1:0] FX_RST = 16'd9600;
    localparam logic [CFG_W-1:0] FY_RST = 16'd9600;

    // datapath widths
    localparam int F2_W   = 2 * CFG_W;          // fx*fy, fx^2, dx^2
    localparam int F4_W   = 4 * CFG_W;          // (fx*fy)^2, dx^2*fy^2
    localparam int N_W    = DEPTH_W + F2_W;     // range*fx*fy
    localparam int NS_W   = N_W / 2;            // split for the n^2 partials
    localparam int NP_W   = 2 * NS_W;
    localparam int D_W    = F4_W + 2;           // sum of three 64-bit terms
    localparam int Z2_W   = DEPTH_W + 1;        // width of t = 2z-1
    localparam int Q_W    = D_W + Z2_W + 2;     // signed t*D
    localparam int RM_W   = D_W + 2 * Z2_W + 2; // signed 4N^2 - t^2*D

    // pipeline layout: four arithmetic stages, then one stage per bit of z
    localparam int SRCH0  = 4;
    localparam int NST    = SRCH0 + DEPTH_W;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
        return (32'(idx) >= MAX_DIM) ? IDX_W'(MAX_DIM - 1) : idx;
    endfunction

endpackage

FILE: design/rrz_ifs.sv
// Valid/ready channel interfaces for pixel requests and depth results.
// Depends on rrz_pkg for the field widths.
interface rrz_req_if;
    logic                          valid;
    logic                          ready;
    logic [rrz_pkg::DEPTH_W-1:0]   range_value;
    logic [rrz_pkg::IDX_W-1:0]     pixel_row;
    logic [rrz_pkg::IDX_W-1:0]     pixel_col;

    modport source (output valid, output range_value, output pixel_row, output pixel_col,
                    input ready);
    modport sink   (input valid, input range_value, input pixel_row, input pixel_col,
                    output ready);
endinterface

interface rrz_res_if;
    logic                          valid;
    logic                          ready;
    logic [rrz_pkg::DEPTH_W-1:0]   z_depth;

    modport source (output valid, output z_depth, input ready);
    modport sink   (input valid, input z_depth, output ready);
endinterface

FILE: design/radial_range_to_z_depth.sv
// Radial range to z depth converter: top level with APB register file and pipeline.
// Depends on rrz_pkg and the channel interfaces in rrz_ifs.sv.
//
// Converts a range measured along a pixel ray into depth along the optical axis,
// z = round(range / sqrt(1 + u^2 + v^2)), correctly rounded (ties up). One pixel
// request is taken every clock unless the full pipeline is stalled; it has 20 stages:
// four stages form N = range*fx*fy, 4N^2 and D = (fx*fy)^2 + (dx*fy)^2 + (dy*fx)^2,
// then sixteen stages each settle one bit of z, MSB first, by a shift-and-add
// test of (2z-1)^2*D <= 4N^2. Stalls are absorbed stage by stage, so requests keep
// flowing into empty stages while a result waits. A zero focal length or zero range
// gives zero. Intrinsics are written through APB (word 0..3: cx, cy, fx, fy, Q12.4)
// and may only change while no pixel is in flight.
module radial_range_to_z_depth (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrz_pkg::ADDR_W-1:0]    paddr,
    input  logic [rrz_pkg::DATA_W-1:0]    pwdata,
    output logic [rrz_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    rrz_req_if.sink                       i_req,
    rrz_res_if.source                     o_res
);

    localparam int NST     = rrz_pkg::NST;
    localparam int SRCH0   = rrz_pkg::SRCH0;
    localparam int DEPTH_W = rrz_pkg::DEPTH_W;
    localparam int CFG_W   = rrz_pkg::CFG_W;
    localparam int F2_W    = rrz_pkg::F2_W;
    localparam int F4_W    = rrz_pkg::F4_W;
    localparam int N_W     = rrz_pkg::N_W;
    localparam int NS_W    = rrz_pkg::NS_W;
    localparam int NP_W    = rrz_pkg::NP_W;
    localparam int D_W     = rrz_pkg::D_W;
    localparam int Q_W     = rrz_pkg::Q_W;
    localparam int RM_W    = rrz_pkg::RM_W;

    // ---------------- registers ----------------
    logic [CFG_W-1:0] r_cx, r_cy, r_fx, r_fy;
    logic [F2_W-1:0]  r_fxy, r_fx2, r_fy2;
    logic [F4_W-1:0]  r_fxy2;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= rrz_pkg::CX_RST;
            r_cy <= rrz_pkg::CY_RST;
            r_fx <= rrz_pkg::FX_RST;
            r_fy <= rrz_pkg::FY_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rrz_pkg::REG_CX: r_cx <= pwdata[CFG_W-1:0];
                rrz_pkg::REG_CY: r_cy <= pwdata[CFG_W-1:0];
                rrz_pkg::REG_FX: r_fx <= pwdata[CFG_W-1:0];
                rrz_pkg::REG_FY: r_fy <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rrz_pkg::REG_CX: prdata = rrz_pkg::DATA_W'(r_cx);
            rrz_pkg::REG_CY: prdata = rrz_pkg::DATA_W'(r_cy);
            rrz_pkg::REG_FX: prdata = rrz_pkg::DATA_W'(r_fx);
            rrz_pkg::REG_FY: prdata = rrz_pkg::DATA_W'(r_fy);
        endcase
    end

    // intrinsic products; each is ready before the first stage that reads it
    always_ff @(posedge i_clk) begin
        r_fxy  <= F2_W'(r_fx) * F2_W'(r_fy);
        r_fx2  <= F2_W'(r_fx) * F2_W'(r_fx);
        r_fy2  <= F2_W'(r_fy) * F2_W'(r_fy);
        r_fxy2 <= F4_W'(r_fxy) * F4_W'(r_fxy);
    end

    // ---------------- pipeline flow control ----------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_rdy;
    logic [NST-1:0] r_zero;

    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || o_res.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    assign i_req.ready = w_rdy[0];
    assign o_res.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ---------------- stage 0: offsets from principal point ----------------
    logic [DEPTH_W-1:0]     r0_range;
    logic [CFG_W-1:0]       r0_dx, r0_dy;
    logic [CFG_W:0]         w_dxs, w_dys, w_ndx, w_ndy;
    logic [rrz_pkg::IDX_W-1:0] w_row, w_col;

    assign w_row = rrz_pkg::clamp_idx(i_req.pixel_row);
    assign w_col = rrz_pkg::clamp_idx(i_req.pixel_col);
    assign w_dxs = (CFG_W+1)'({w_col, 4'b0000}) - (CFG_W+1)'(r_cx);
    assign w_dys = (CFG_W+1)'({w_row, 4'b0000}) - (CFG_W+1)'(r_cy);
    assign w_ndx = -w_dxs;
    assign w_ndy = -w_dys;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_range  <= i_req.range_value;
            r0_dx     <= w_dxs[CFG_W] ? w_ndx[CFG_W-1:0] : w_dxs[CFG_W-1:0];
            r0_dy     <= w_dys[CFG_W] ? w_ndy[CFG_W-1:0] : w_dys[CFG_W-1:0];
            r_zero[0] <= (r_fx == '0) || (r_fy == '0) || (i_req.range_value == '0);
        end
    end

    // ---------------- stage 1: N and squared offsets ----------------
    logic [N_W-1:0]  r1_n;
    logic [F2_W-1:0] r1_dx2, r1_dy2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_n      <= N_W'(r0_range) * N_W'(r_fxy);
            r1_dx2    <= F2_W'(r0_dx) * F2_W'(r0_dx);
            r1_dy2    <= F2_W'(r0_dy) * F2_W'(r0_dy);
            r_zero[1] <= r_zero[0];
        end
    end

    // ---------------- stage 2: D terms and N^2 partial products ----------------
    logic [F4_W-1:0] r2_a, r2_b;
    logic [NP_W-1:0] r2_hh, r2_hl, r2_ll;
    logic [NS_W-1:0] w_nh, w_nl;

    assign w_nh = r1_n[N_W-1:NS_W];
    assign w_nl = r1_n[NS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_a      <= F4_W'(r1_dx2) * F4_W'(r_fy2);
            r2_b      <= F4_W'(r1_dy2) * F4_W'(r_fx2);
            r2_hh     <= NP_W'(w_nh) * NP_W'(w_nh);
            r2_hl     <= NP_W'(w_nh) * NP_W'(w_nl);
            r2_ll     <= NP_W'(w_nl) * NP_W'(w_nl);
            r_zero[2] <= r_zero[1];
        end
    end

    // ---------------- stage 3: D, 4N^2 - D, -D (state for z = 0, t = -1) ----------------
    logic [D_W-1:0]             r_d  [SRCH0-1:NST-2];
    logic signed [RM_W-1:0]     r_rm [SRCH0-1:NST-2];
    logic signed [Q_W-1:0]      r_q  [SRCH0-1:NST-2];
    logic [DEPTH_W-1:0]         r_z  [SRCH0:NST-1];
    logic [D_W-1:0]             w_d3;
    logic [RM_W-1:0]            w_fn2;

    assign w_d3  = D_W'(r_fxy2) + D_W'(r2_a) + D_W'(r2_b);
    assign w_fn2 = (RM_W'(r2_hh) << (2 * NS_W + 2)) + (RM_W'(r2_hl) << (NS_W + 3))
                 + (RM_W'(r2_ll) << 2);

    always_ff @(posedge i_clk) begin
        if (w_rdy[SRCH0-1]) begin
            r_d[SRCH0-1]    <= w_d3;
            r_rm[SRCH0-1]   <= $signed(w_fn2 - RM_W'(w_d3));
            r_q[SRCH0-1]    <= -$signed(Q_W'(w_d3));
            r_zero[SRCH0-1] <= r_zero[SRCH0-2];
        end
    end

    // ---------------- search stages: one bit of z each, MSB first ----------------
    // With t = 2z-1, keep rm = 4N^2 - t^2*D and q = t*D. Setting bit B adds 2^(B+1)
    // to t, so rm drops by q<<(B+2) + D<<(2B+2) and q grows by D<<(B+1).
    genvar s;
    generate
        for (s = SRCH0; s < NST; s++) begin : g_srch
            localparam int B = NST - 1 - s;

            logic [DEPTH_W-1:0]     w_zprev;
            logic [DEPTH_W-1:0]     w_zc;
            logic signed [RM_W-1:0] w_qs, w_ds, w_cand;
            logic                   w_take;

            if (s == SRCH0) begin : g_first
                assign w_zprev = '0;
            end else begin : g_next
                assign w_zprev = r_z[s-1];
            end

            assign w_qs   = RM_W'(r_q[s-1]) <<< (B + 2);
            assign w_ds   = $signed(RM_W'(r_d[s-1])) <<< (2 * B + 2);
            assign w_cand = r_rm[s-1] - w_qs - w_ds;
            assign w_take = !w_cand[RM_W-1];
            assign w_zc   = w_zprev | (DEPTH_W'(1) << B);

            if (s < NST - 1) begin : g_mid
                always_ff @(posedge i_clk) begin
                    if (w_rdy[s]) begin
                        r_d[s]    <= r_d[s-1];
                        r_rm[s]   <= w_take ? w_cand : r_rm[s-1];
                        r_q[s]    <= w_take ? r_q[s-1] + ($signed(Q_W'(r_d[s-1])) <<< (B + 1))
                                            : r_q[s-1];
                        r_z[s]    <= w_take ? w_zc : w_zprev;
                        r_zero[s] <= r_zero[s-1];
                    end
                end
            end else begin : g_last
                always_ff @(posedge i_clk) begin
                    if (w_rdy[s]) begin
                        r_z[s]    <= r_zero[s-1] ? '0 : (w_take ? w_zc : w_zprev);
                        r_zero[s] <= r_zero[s-1];
                    end
                end
            end
        end
    endgenerate

    assign o_res.z_depth = r_z[NST-1];

endmodule
